>>> rtl/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// shared types, widths and helpers of the nearest neighbour tour unit
// ----------------------------------------------------------------------------
package nnt_pkg;

	localparam int unsigned MAX_CITIES_DEF = 64;
	localparam int unsigned POS_W          = 6;
	localparam int unsigned LEG_W          = 30;
	localparam int unsigned TOTAL_W        = 40;
	localparam int unsigned RAD_W          = 50;
	localparam int unsigned ROOT_W         = RAD_W / 2;
	localparam int unsigned REM_W          = ROOT_W + 3;
	localparam int unsigned PROD_W         = ROOT_W + 17;
	localparam int unsigned W_FRAC         = 13;

	typedef struct packed {
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic [15:0]        cost_weight;
		logic               last_city;
	} city_t;

	typedef struct packed {
		logic [POS_W-1:0]   tour_position;
		logic [POS_W-1:0]   city_index;
		logic [LEG_W-1:0]   leg_length;
		logic [TOTAL_W-1:0] running_total;
		logic               overflowed;
		logic               last_result;
	} result_t;

	// one stored city
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
	} point_t;

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
		input logic [LEG_W-1:0] v);
		logic [TOTAL_W:0] s;
		s = {1'b0, t} + {{(TOTAL_W-LEG_W+1){1'b0}}, v};
		sat_add = s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
	endfunction

endpackage

>>> rtl/nearest_neighbor_tour_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_unit
// greedy nearest neighbour tour over a loaded set of weighted cities
// ----------------------------------------------------------------------------
// usage
//  - input: a city transaction is taken on a clock edge with start high and
//    busy low; one city per cycle while loading
//  - cities go into a single-port-write, registered-read store in load order;
//    a city arriving with the store full is dropped and the overflow flag set
//  - the transaction with last_city high raises busy and builds the tour from
//    city 0; each unvisited candidate is read from the store and run through
//    the leg unit: two squares, a 25 step bit-serial square root, weight
//    product and scaling
//  - a tour position scans its unvisited candidates one after another; the
//    next candidate is read only once the leg unit is done with the last
//  - output: each result is on result for exactly one cycle with done high;
//    the receiver cannot hold it off
//  - the final result (last_result) includes the leg back to city 0; busy
//    is already low in the cycle it is presented and load state is cleared
//  - reset clears the fill count, visited bits and overflow flag; store
//    contents are only read once written in the current set
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_unit
	import nnt_pkg::*;
#(
	parameter int unsigned MAX_CITIES = MAX_CITIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  city_t   city,
	output logic    done,
	output result_t result
);

	localparam int unsigned IW = $clog2(MAX_CITIES);
	localparam int unsigned CW = $clog2(MAX_CITIES + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD0   = 3'd1;
	localparam logic [2:0] ST_RD0W  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_SWAIT = 3'd4;
	localparam logic [2:0] ST_LEG   = 3'd5;
	localparam logic [2:0] ST_PICK  = 3'd6;
	localparam logic [2:0] ST_RET   = 3'd7;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q, pos_q, i_q;
	logic                  ovf_q, have_q, done_q;
	logic [MAX_CITIES-1:0] visited_q;
	logic [LEG_W-1:0]      best_q;
	logic [IW-1:0]         pick_q;
	logic [TOTAL_W-1:0]    total_q;
	point_t                cur_q, home_q, cand_q, pickpt_q;
	result_t               result_q;

	logic                  accept, room, we, leg_start, leg_done, ret_now;
	logic [IW-1:0]         raddr;
	point_t                rdata, leg_a, leg_b;
	logic [LEG_W-1:0]      leg;
	logic [TOTAL_W-1:0]    sum;

	assign accept  = start && (state_q == ST_IDLE);
	assign room    = (count_q < CW'(MAX_CITIES));
	assign we      = accept && room;
	assign busy    = (state_q != ST_IDLE);
	assign sum     = sat_add(total_q, best_q);
	assign ret_now = ((pos_q + CW'(1)) == count_q);

	// store read address: candidate during the scan, city 0 otherwise
	assign raddr = (state_q == ST_SCAN) ? i_q[IW-1:0] : '0;

	// leg operands: current city to candidate, or final city back home
	always_comb begin
		if (state_q == ST_PICK) begin
			leg_a = pickpt_q;
			leg_b = home_q;
		end else begin
			leg_a = cur_q;
			leg_b = rdata;
		end
		leg_start = (state_q == ST_SWAIT) || ((state_q == ST_PICK) && ret_now);
	end

	nnt_store #(
		.DEPTH (MAX_CITIES),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IW-1:0]),
		.wdata ({city.x_coord, city.y_coord, city.cost_weight}),
		.raddr (raddr),
		.rdata (rdata)
	);

	nnt_leg u_leg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (leg_start),
		.pa     (leg_a),
		.pb     (leg_b),
		.done   (leg_done),
		.leg    (leg)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			visited_q <= '0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
			pos_q     <= '0;
			i_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (city.last_city) begin
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: state_q <= ST_RD0W;
				ST_RD0W: begin
					done_q <= 1'b1;
					if (count_q == CW'(1)) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						visited_q <= MAX_CITIES'(1);
						pos_q     <= CW'(1);
						i_q       <= '0;
						have_q    <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (i_q == count_q) begin
						state_q <= ST_PICK;
					end else if (visited_q[i_q[IW-1:0]]) begin
						i_q <= i_q + CW'(1);
					end else begin
						state_q <= ST_SWAIT;
					end
				end
				ST_SWAIT: state_q <= ST_LEG;
				ST_LEG: begin
					if (leg_done) begin
						have_q  <= 1'b1;
						i_q     <= i_q + CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_PICK: begin
					visited_q[pick_q] <= 1'b1;
					if (ret_now) begin
						state_q <= ST_RET;
					end else begin
						done_q  <= 1'b1;
						pos_q   <= pos_q + CW'(1);
						i_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_RET: begin
					if (leg_done) begin
						done_q    <= 1'b1;
						count_q   <= '0;
						ovf_q     <= 1'b0;
						visited_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD0W: begin
				cur_q                  <= rdata;
				home_q                 <= rdata;
				total_q                <= '0;
				result_q.tour_position <= '0;
				result_q.city_index    <= '0;
				result_q.leg_length    <= '0;
				result_q.running_total <= '0;
				result_q.overflowed    <= ovf_q;
				result_q.last_result   <= (count_q == CW'(1));
			end
			ST_SWAIT: cand_q <= rdata;
			ST_LEG: begin
				// strict less keeps the lowest index on a tie
				if (leg_done && (!have_q || (leg < best_q))) begin
					best_q   <= leg;
					pick_q   <= i_q[IW-1:0];
					pickpt_q <= cand_q;
				end
			end
			ST_PICK: begin
				cur_q                  <= pickpt_q;
				total_q                <= sum;
				result_q.tour_position <= POS_W'(pos_q);
				result_q.city_index    <= POS_W'(pick_q);
				result_q.leg_length    <= best_q;
				result_q.running_total <= sum;
				result_q.overflowed    <= ovf_q;
				result_q.last_result   <= 1'b0;
			end
			ST_RET: begin
				// final position carries the leg back to city 0 in its total
				if (leg_done) begin
					result_q.running_total <= sat_add(total_q, leg);
					result_q.last_result   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result transactions back to back");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CITIES))
		else $error("fill count beyond capacity");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_result) |-> !busy)
		else $error("busy after final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last_result) |-> busy)
		else $error("tour ended without final result");
`endif

endmodule

>>> rtl/nnt_store.sv
// ----------------------------------------------------------------------------
// nnt_store
// city store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module nnt_store
	import nnt_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_CITIES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/nnt_leg.sv
// ----------------------------------------------------------------------------
// nnt_leg
// weighted leg length: squares, bit-serial square root, weight product
// ----------------------------------------------------------------------------
module nnt_leg
	import nnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  point_t           pa,
	input  point_t           pb,
	output logic             done,
	output logic [LEG_W-1:0] leg
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_MX   = 3'd1;
	localparam logic [2:0] L_MY   = 3'd2;
	localparam logic [2:0] L_SUM  = 3'd3;
	localparam logic [2:0] L_SQ   = 3'd4;
	localparam logic [2:0] L_MUL  = 3'd5;
	localparam logic [2:0] L_FIN  = 3'd6;

	logic [2:0]              state_q;
	logic [4:0]              cnt_q;
	logic [15:0]             ux_q, uy_q;
	logic [16:0]             s_q;
	logic [31:0]             sqx_q, sqy_q;
	logic [RAD_W-1:0]        rad_q;
	logic [REM_W-1:0]        rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic [PROD_W-1:0]       prod_q;
	logic [LEG_W-1:0]        leg_q;
	logic                    done_q;

	logic signed [16:0]      dx, dy;
	logic [REM_W-1:0]        rem_sh, trial;
	logic [PROD_W-W_FRAC-1:0] scaled;

	always_comb begin
		dx     = 17'(pb.x) - 17'(pa.x);
		dy     = 17'(pb.y) - 17'(pa.y);
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		scaled = prod_q[PROD_W-1:W_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_MX;
					end
				end
				L_MX: state_q <= L_MY;
				L_MY: state_q <= L_SUM;
				L_SUM: begin
					cnt_q   <= '0;
					state_q <= L_SQ;
				end
				L_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ROOT_W - 1)) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: state_q <= L_FIN;
				L_FIN: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				ux_q <= dx[16] ? 16'(-dx) : dx[15:0];
				uy_q <= dy[16] ? 16'(-dy) : dy[15:0];
				s_q  <= 17'(pa.w) + 17'(pb.w);
			end
			L_MX: sqx_q <= ux_q * ux_q;
			L_MY: sqy_q <= uy_q * uy_q;
			L_SUM: begin
				rad_q  <= {1'b0, 33'(sqx_q) + 33'(sqy_q), 16'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			L_SQ: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			L_MUL: prod_q <= PROD_W'(root_q) * PROD_W'(s_q);
			// max root * max weight sum >> W_FRAC stays below 2^29, under the leg limit
			L_FIN: leg_q <= LEG_W'(scaled);
			default: ;
		endcase
	end

	assign done = done_q;
	assign leg  = leg_q;

endmodule

>>> tb/tb_nearest_neighbor_tour_unit.sv
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_tour_unit
// self-checking testbench of the greedy nearest neighbour tour unit
// ----------------------------------------------------------------------------
// cities are loaded as command transactions. The testbench keeps its own
// copy of the city store. On every last_city transaction it builds the
// expected tour: nearest unvisited city, lowest index on a tie, weighted Q.8
// legs and a saturating running total. Each result strobe is compared field
// by field with the oldest expected tour position.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_tour_unit
	import nnt_pkg::*;
();

	localparam int unsigned CAPACITY   = MAX_CITIES_DEF;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam longint unsigned LEG_CAP   = (64'd1 << LEG_W) - 1;
	localparam longint unsigned TOTAL_CAP = (64'd1 << TOTAL_W) - 1;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	city_t   city;
	logic    done;
	result_t result;

	nearest_neighbor_tour_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.city   (city),
		.done   (done),
		.result (result)
	);

	// shadow copy of the city store and load state
	logic signed [15:0] shadow_x [CAPACITY];
	logic signed [15:0] shadow_y [CAPACITY];
	logic [15:0]        shadow_w [CAPACITY];
	int unsigned        shadow_count;
	bit                 shadow_ovf;

	result_t tour_queue [$];
	bit      failed;
	bit      gaps_on;
	int      stall_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// tour predictor
	// ------------------------------------------------------------------------

	// floor of the square root, one result bit per step
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// weighted distance in Q.8 between two stored cities
	function automatic longint unsigned weighted_leg(int unsigned a, int unsigned b);
		longint signed   dx;
		longint signed   dy;
		longint unsigned sq;
		longint unsigned span;
		longint unsigned wsum;
		longint unsigned leg;
		dx   = longint'(shadow_x[b]) - longint'(shadow_x[a]);
		dy   = longint'(shadow_y[b]) - longint'(shadow_y[a]);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sq   = longint'(dx * dx + dy * dy);
		span = root_floor(sq << 16);
		wsum = longint'(shadow_w[a]) + longint'(shadow_w[b]);
		leg  = (span * wsum) >> W_FRAC;
		return (leg > LEG_CAP) ? LEG_CAP : leg;
	endfunction

	function automatic longint unsigned total_add(longint unsigned t, longint unsigned v);
		return (t + v > TOTAL_CAP) ? TOTAL_CAP : t + v;
	endfunction

	function automatic result_t tour_entry(int unsigned pos, int unsigned idx,
		longint unsigned leg, longint unsigned total, bit fin);
		result_t r;
		r.tour_position = pos[POS_W-1:0];
		r.city_index    = idx[POS_W-1:0];
		r.leg_length    = leg[LEG_W-1:0];
		r.running_total = total[TOTAL_W-1:0];
		r.overflowed    = shadow_ovf;
		r.last_result   = fin;
		return r;
	endfunction

	// store one accepted city; on last_city build the expected tour
	task automatic predict_tour(city_t c);
		bit [CAPACITY-1:0] seen;
		int unsigned       here;
		int unsigned       pick;
		longint unsigned   best;
		longint unsigned   leg;
		longint unsigned   total;
		bit                have;
		if (shadow_count < CAPACITY) begin
			shadow_x[shadow_count] = c.x_coord;
			shadow_y[shadow_count] = c.y_coord;
			shadow_w[shadow_count] = c.cost_weight;
			shadow_count++;
		end else begin
			shadow_ovf = 1'b1;
		end
		if (!c.last_city)
			return;
		seen    = '0;
		seen[0] = 1'b1;
		here    = 0;
		total   = 0;
		tour_queue.push_back(tour_entry(0, 0, 0, 0, shadow_count == 1));
		for (int unsigned pos = 1; pos < shadow_count; pos++) begin
			have = 1'b0;
			best = 0;
			pick = 0;
			for (int unsigned i = 0; i < shadow_count; i++) begin
				if (seen[i])
					continue;
				leg = weighted_leg(here, i);
				// strict compare keeps the lowest index on a tie
				if (!have || leg < best) begin
					best = leg;
					pick = i;
					have = 1'b1;
				end
			end
			seen[pick] = 1'b1;
			total      = total_add(total, best);
			here       = pick;
			// final position also carries the leg home to city 0
			if (pos + 1 == shadow_count)
				total = total_add(total, weighted_leg(here, 0));
			tour_queue.push_back(tour_entry(pos, pick, best, total, pos + 1 == shadow_count));
		end
		shadow_count = 0;
		shadow_ovf   = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// result checking, one tour position per done strobe
	// ------------------------------------------------------------------------
	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (tour_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				failed = 1'b1;
			end else begin
				want = tour_queue.pop_front();
				check_field("tour_position", want.tour_position, result.tour_position);
				check_field("city_index", want.city_index, result.city_index);
				check_field("leg_length", want.leg_length, result.leg_length);
				check_field("running_total", want.running_total, result.running_total);
				check_field("overflowed", want.overflowed, result.overflowed);
				check_field("last_result", want.last_result, result.last_result);
			end
		end
	end

	// watchdog: cycles with no transaction in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("** nearest_neighbor_tour_unit: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers; every task starts and ends just after a falling edge
	// ------------------------------------------------------------------------
	task automatic send_city(city_t c);
		start <= 1'b1;
		city  <= c;
		// busy is stable between falling edge and the next rising edge
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_tour(c);
		@(negedge clk);
	endtask

	// random idle burst between transactions
	task automatic maybe_idle();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic wait_tours_done();
		start <= 1'b0;
		do
			@(negedge clk);
		while (tour_queue.size() != 0 || busy);
	endtask

	function automatic city_t make_city(int signed x, int signed y, int unsigned w, bit fin);
		city_t c;
		c.x_coord     = x[15:0];
		c.y_coord     = y[15:0];
		c.cost_weight = w[15:0];
		c.last_city   = fin;
		return c;
	endfunction

	// full-range or clustered coordinates; clusters give ties and short legs
	function automatic city_t random_city(bit fin);
		if ($urandom_range(0, 2) == 0)
			return make_city($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
				$urandom_range(0, 3) * 4096, fin);
		return make_city($urandom(), $urandom(), $urandom(), fin);
	endfunction

	task automatic send_set(int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			send_city(random_city(i == n - 1));
			maybe_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_single_city();
		send_city(make_city(-32768, 32767, 65535, 1'b1));
		maybe_idle();
	endtask

	task automatic test_extremes();
		// opposite corners with largest and zero weights
		send_city(make_city(-32768, -32768, 65535, 1'b0));
		send_city(make_city(32767, 32767, 65535, 1'b0));
		send_city(make_city(32767, -32768, 0, 1'b0));
		send_city(make_city(-32768, 32767, 0, 1'b1));
		maybe_idle();
		// duplicate cities: zero legs
		send_city(make_city(5, 5, 4096, 1'b0));
		send_city(make_city(5, 5, 4096, 1'b1));
		maybe_idle();
	endtask

	task automatic test_ties();
		// four equidistant neighbours of city 0, lowest index must win
		send_city(make_city(0, 0, 4096, 1'b0));
		send_city(make_city(0, 10, 4096, 1'b0));
		send_city(make_city(10, 0, 4096, 1'b0));
		send_city(make_city(-10, 0, 4096, 1'b0));
		send_city(make_city(0, -10, 4096, 1'b1));
		maybe_idle();
	endtask

	task automatic test_capacity();
		// exactly full
		send_set(CAPACITY);
		wait_tours_done();
		// overflow: extra cities dropped, last_city on a dropped one
		for (int unsigned i = 0; i < CAPACITY + 2; i++) begin
			send_city(random_city(i == CAPACITY + 1));
			maybe_idle();
		end
		// flag must clear for the next set
		send_set(3);
	endtask

	task automatic test_random_sets(int unsigned items);
		int unsigned sent;
		int unsigned n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
			send_set(n);
			sent += n;
		end
	endtask

	initial begin
		start        = 1'b0;
		city         = '0;
		arst_n       = 1'b0;
		failed       = 1'b0;
		gaps_on      = 1'b1;
		shadow_count = 0;
		shadow_ovf   = 1'b0;
		stall_cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_city();
		test_extremes();
		test_ties();
		test_capacity();
		test_random_sets(130);
		// hold off the sender until every tour has been reported
		wait_tours_done();
		test_random_sets(120);
		// last part runs back to back
		gaps_on = 1'b0;
		test_random_sets(100);

		wait_tours_done();
		repeat (100) @(negedge clk);
		if (failed || tour_queue.size() != 0)
			$display("** nearest_neighbor_tour_unit: FAILED **");
		else
			$display("** nearest_neighbor_tour_unit: PASSED **");
		$finish;
	end

endmodule

>>> nearest_neighbor_tour_unit.f
rtl/nnt_pkg.sv
rtl/nnt_store.sv
rtl/nnt_leg.sv
rtl/nearest_neighbor_tour_unit.sv
tb/tb_nearest_neighbor_tour_unit.sv
